// File: hw/rtl/lsrp_pkg.sv
package lsrp_pkg;

    // Stream framing
    localparam int REC_BYTES        = 5;
    localparam int DESC_BYTES       = 7;
    localparam int MIN_FRAME_POINTS = 10;

    // Default point capacity of one bank
    localparam int DEF_POINT_CAPACITY = 256;

    // Stored point word: range [15:0], angle [30:16], quality [36:31]
    localparam int QUAL_W  = 6;
    localparam int ANGLE_W = 15;
    localparam int RANGE_W = 16;
    localparam int POINT_W = QUAL_W + ANGLE_W + RANGE_W;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 56;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE      = 2'd0,
        CFG_MIN_QUALITY = 2'd1,
        CFG_MAX_RANGE   = 2'd2,
        CFG_EXPECT_DESC = 2'd3
    } t_cfg_idx;

endpackage

// File: hw/rtl/lidar_scan_record_parser_core.sv
// Lidar scan record parser.
// Slave stream: one item per transfer. tuser carries op (0 = received link
// byte, 1 = read a published point); tdata carries rx_byte and read_index.
// Every accepted item yields exactly one transfer on the master stream with
// the descriptor/record flags, the published point count and, for a read,
// the point taken from the published bank.
// Throughput: one item per cycle while the master side accepts results. The
// middle stage waits for the point memory, whose registered read port feeds
// the output register. Two registers sit between the sides, so the block
// takes one more item while a result waits.
// Point memory: 2 x POINT_CAPACITY words, one bank filled while the other is
// published. No clearing pass: entries are only read after being written.
// Reset: counts, bank select, descriptor/measuring mode and byte phase clear;
// registers return to enable 0, min_quality 0, max_range 65535, descriptor 0.
// Stall: when the master side holds tready low the output register holds,
// the middle stage fills, and then s_axis_tready drops until it drains.
// Configuration is written through i_cfg_we/i_cfg_idx/i_cfg_data; the user
// must write it only while idle, as the block itself does not enforce this.
module lidar_scan_record_parser_core
    import lsrp_pkg::*;
#(
    parameter int POINT_CAPACITY = DEF_POINT_CAPACITY,
    localparam int CNT_W   = $clog2(POINT_CAPACITY + 1),
    localparam int OUT_BITS = 5 + CNT_W + 1 + POINT_W,
    localparam int OUT_W   = ((OUT_BITS + 7) / 8) * 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // Input stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [15:0]           s_axis_tdata,  // rx_byte[7:0], read_index[15:8]
    input  logic                  s_axis_tuser,  // op
    // Result stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // descriptor_ok, descriptor_error, record_done, point_kept, frame_end,
    // published_count, read_valid, read_quality, read_angle, read_range,
    // zero pad
    output logic [OUT_W-1:0]      m_axis_tdata
);

    localparam int AW    = $clog2(2 * POINT_CAPACITY);
    localparam int CMP_W = (CNT_W > 8) ? CNT_W : 8;

    // Configuration registers
    logic                  r_enable;
    logic [QUAL_W-1:0]     r_min_q;
    logic [RANGE_W-1:0]    r_max_rng;
    logic [CFG_DATA_W-1:0] r_desc;

    // Parser state
    logic             r_bank, n_bank;
    logic [CNT_W-1:0] r_wc, n_wc;
    logic [CNT_W-1:0] r_pub, n_pub;
    logic             r_meas, n_meas;
    logic [2:0]       r_phase, n_phase;
    logic [7:0]       r_part [0:5];

    // Middle stage: waits for the memory read
    logic             r_s1_v;
    logic [4:0]       r_s1_flags, n_flags;   // ok, err, done, kept, frame_end
    logic [CNT_W-1:0] r_s1_pc;
    logic             r_s1_rv, n_rv;

    // Output register
    logic             r_out_v;
    logic [OUT_W-1:0] r_out_data;

    logic             in_acc, s1_adv;
    logic             op;
    logic [7:0]       rx, idx;
    logic [CNT_W-1:0] wc_cur, pub_cur, wc_after;
    logic             last_byte;
    logic [QUAL_W-1:0]  rec_q;
    logic [ANGLE_W-1:0] rec_ang;
    logic [RANGE_W-1:0] rec_rng;
    logic             rec_keep, part_we;
    logic             ram_we, ram_re;
    logic [AW-1:0]    ram_waddr, ram_raddr;
    logic [POINT_W-1:0] ram_rdata;
    logic [QUAL_W-1:0]  rd_q;
    logic [ANGLE_W-1:0] rd_ang;
    logic [RANGE_W-1:0] rd_rng;

    assign op  = s_axis_tuser;
    assign rx  = s_axis_tdata[7:0];
    assign idx = s_axis_tdata[15:8];

    assign s1_adv        = !r_out_v || m_axis_tready;
    assign s_axis_tready = !r_s1_v || s1_adv;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    // Link disabled: counts read as zero
    assign wc_cur  = r_enable ? r_wc  : '0;
    assign pub_cur = r_enable ? r_pub : '0;

    assign last_byte = r_meas ? (r_phase == 3'(REC_BYTES - 1))
                              : (r_phase == 3'(DESC_BYTES - 1));

    // Record fields: bytes 0..3 gathered, byte 4 is the current one
    assign rec_q    = r_part[0][7:2];
    assign rec_ang  = {r_part[2], r_part[1][7:1]};
    assign rec_rng  = {rx, r_part[3]};
    assign rec_keep = (rec_q >= r_min_q) && (rec_rng <= r_max_rng)
                      && (wc_cur < CNT_W'(POINT_CAPACITY));

    always_comb begin
        n_bank  = r_bank;
        n_wc    = wc_cur;
        n_pub   = pub_cur;
        n_meas  = r_meas;
        n_phase = r_phase;
        n_flags = '0;
        n_rv    = 1'b0;
        part_we = 1'b0;
        ram_we  = 1'b0;
        ram_re  = 1'b0;
        wc_after = wc_cur + CNT_W'(rec_keep);
        if (!op) begin
            if (r_enable) begin
                if (last_byte) begin
                    n_phase = '0;
                    if (r_meas) begin
                        n_flags[2] = 1'b1;
                        n_flags[3] = rec_keep;
                        ram_we     = in_acc && rec_keep;
                        n_wc       = wc_after;
                        if (r_part[0][1:0] == 2'b01) begin
                            n_flags[4] = 1'b1;
                            n_wc       = '0;
                            if (wc_after > CNT_W'(MIN_FRAME_POINTS)) begin
                                n_pub  = wc_after;
                                n_bank = !r_bank;
                            end else begin
                                n_pub = '0;
                            end
                        end
                    end else if ({rx, r_part[5], r_part[4], r_part[3], r_part[2],
                                  r_part[1], r_part[0]} == r_desc) begin
                        n_flags[0] = 1'b1;
                        n_meas     = 1'b1;
                    end else begin
                        n_flags[1] = 1'b1;
                    end
                end else begin
                    part_we = 1'b1;
                    n_phase = r_phase + 3'd1;
                end
            end
        end else begin
            ram_re = in_acc;
            n_rv   = (CMP_W'(idx) < CMP_W'(pub_cur))
                     && (CMP_W'(idx) < CMP_W'(POINT_CAPACITY));
        end
    end

    // Working bank is written, the other bank is published; a read never
    // touches the bank a write goes to, so no forwarding is needed.
    assign ram_waddr = r_bank ? (AW'(POINT_CAPACITY) + AW'(wc_cur)) : AW'(wc_cur);
    assign ram_raddr = r_bank ? AW'(idx) : (AW'(POINT_CAPACITY) + AW'(idx));

    lsrp_ram #(
        .WIDTH (POINT_W),
        .DEPTH (2 * POINT_CAPACITY)
    ) u_point_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata ({rec_q, rec_ang, rec_rng}),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable  <= 1'b0;
            r_min_q   <= '0;
            r_max_rng <= '1;
            r_desc    <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_ENABLE:      r_enable  <= i_cfg_data[0];
                CFG_MIN_QUALITY: r_min_q   <= i_cfg_data[QUAL_W-1:0];
                CFG_MAX_RANGE:   r_max_rng <= i_cfg_data[RANGE_W-1:0];
                CFG_EXPECT_DESC: r_desc    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Parser state update on each accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bank  <= 1'b0;
            r_wc    <= '0;
            r_pub   <= '0;
            r_meas  <= 1'b0;
            r_phase <= '0;
        end else if (in_acc) begin
            r_bank  <= n_bank;
            r_wc    <= n_wc;
            r_pub   <= n_pub;
            r_meas  <= n_meas;
            r_phase <= n_phase;
        end
    end

    // Gather bytes of the current group
    always_ff @(posedge i_clk) begin
        if (in_acc && part_we) begin
            r_part[r_phase] <= rx;
        end
    end

    // Middle stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (s_axis_tready) begin
            r_s1_v <= in_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_flags <= n_flags;
            r_s1_pc    <= n_pub;
            r_s1_rv    <= n_rv;
        end
    end

    // Merge read data; zero the point fields unless the read hit
    assign rd_q   = r_s1_rv ? ram_rdata[POINT_W-1 -: QUAL_W] : '0;
    assign rd_ang = r_s1_rv ? ram_rdata[RANGE_W +: ANGLE_W]  : '0;
    assign rd_rng = r_s1_rv ? ram_rdata[RANGE_W-1:0]         : '0;

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (s1_adv) begin
            r_out_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_v) begin
            r_out_data <= OUT_W'({rd_rng, rd_ang, rd_q, r_s1_rv, r_s1_pc,
                                  r_s1_flags[4], r_s1_flags[3], r_s1_flags[2],
                                  r_s1_flags[1], r_s1_flags[0]});
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = r_out_data;

`ifndef ASSERT_OFF
    a_wc_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wc <= CNT_W'(POINT_CAPACITY))
        else $error("working count beyond bank capacity");

    a_pub_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pub == '0) || (r_pub > CNT_W'(MIN_FRAME_POINTS)))
        else $error("published frame below minimum size");

    a_kept_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_v && r_s1_flags[3] |-> r_s1_flags[2] && !r_s1_rv)
        else $error("point kept without a completed record");

    a_read_noflags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_v && r_s1_rv |-> r_s1_flags == '0)
        else $error("read result carries parser flags");

    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_v && !s1_adv |=> r_s1_v && $stable(r_s1_pc))
        else $error("middle stage lost while output stalled");
`endif

endmodule

// File: hw/rtl/lsrp_ram.sv
module lsrp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // Hold read data until the next read
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: tb/lsrp_tb_pkg.sv
package lsrp_tb_pkg;

    // Item kind carried on s_axis_tuser
    typedef enum logic {
        OP_RX_BYTE    = 1'b0,
        OP_READ_POINT = 1'b1
    } t_item_op;

    // Low two bits of a record's first byte that mark the start of a new scan
    localparam logic [1:0] START_FLAG = 2'b01;

    // Result word as it leaves on m_axis_tdata, last field in the lowest bits
    typedef struct packed {
        logic [3:0]  pad;
        logic [15:0] range;
        logic [14:0] angle;
        logic [5:0]  quality;
        logic        rd_valid;
        logic [8:0]  count;
        logic        frame_end;
        logic        kept;
        logic        rec_done;
        logic        desc_err;
        logic        desc_ok;
    } t_scan_result;

endpackage

// File: tb/lsrp_scoreboard.sv
module lsrp_scoreboard
    import lsrp_pkg::*;
    import lsrp_tb_pkg::*;
(
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [CFG_IDX_W-1:0]            i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]           i_cfg_data,
    input  logic                            s_axis_tvalid,
    input  logic                            s_axis_tready,
    input  logic [15:0]                     s_axis_tdata,  // rx_byte[7:0], read_index[15:8]
    input  logic                            s_axis_tuser,  // op
    input  logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // descriptor_ok, descriptor_error, record_done, point_kept, frame_end,
    // published_count, read_valid, read_quality, read_angle, read_range, pad
    input  logic [$bits(t_scan_result)-1:0] m_axis_tdata,
    output int                              o_failures,
    output int                              o_pending
);

    localparam int CAP = DEF_POINT_CAPACITY;

    // Register copies
    logic        link_en;
    logic [5:0]  min_quality;
    logic [15:0] max_range;
    logic [55:0] desc_word;

    // Parser state
    logic [POINT_W-1:0] point_mem [2][CAP];
    logic               fill_bank;
    logic [8:0]         fill_count;
    logic [8:0]         shown_count;
    logic               in_scan;
    logic [2:0]         byte_phase;
    logic [47:0]        gathered;

    t_scan_result expect_q[$];
    int           failures = 0;

    assign o_failures = failures;

    function automatic t_scan_result parse_item(t_item_op op, logic [7:0] rx, logic [7:0] ix);
        t_scan_result       res;
        logic [55:0]        word;
        logic [5:0]         qual;
        logic [14:0]        ang;
        logic [15:0]        rng;
        logic [POINT_W-1:0] entry;
        res = '0;
        if (!link_en) begin
            fill_count  = '0;
            shown_count = '0;
        end
        if (op == OP_RX_BYTE) begin
            if (link_en) begin
                word = {8'd0, gathered} | (56'(rx) << (8 * byte_phase));
                if (int'(byte_phase) + 1 >= (in_scan ? REC_BYTES : DESC_BYTES)) begin
                    if (in_scan) begin
                        qual = word[7:2];
                        ang  = {word[23:16], word[15:9]};
                        rng  = word[39:24];
                        res.rec_done = 1'b1;
                        if (qual >= min_quality && rng <= max_range && fill_count < CAP) begin
                            point_mem[fill_bank][fill_count[$clog2(CAP)-1:0]] =
                                {qual, ang, rng};
                            fill_count++;
                            res.kept = 1'b1;
                        end
                        if (word[1:0] == START_FLAG) begin
                            // publish only frames with enough points
                            if (fill_count > MIN_FRAME_POINTS) begin
                                shown_count = fill_count;
                                fill_bank   = !fill_bank;
                            end else begin
                                shown_count = '0;
                            end
                            fill_count    = '0;
                            res.frame_end = 1'b1;
                        end
                    end else if (word == desc_word) begin
                        res.desc_ok = 1'b1;
                        in_scan     = 1'b1;
                    end else begin
                        res.desc_err = 1'b1;
                    end
                    byte_phase = '0;
                    gathered   = '0;
                end else begin
                    byte_phase++;
                    gathered = word[47:0];
                end
            end
        end else if (ix < shown_count) begin
            entry        = point_mem[!fill_bank][ix];
            res.rd_valid = 1'b1;
            res.quality  = entry[36:31];
            res.angle    = entry[30:16];
            res.range    = entry[15:0];
        end
        res.count = shown_count;
        return res;
    endfunction

    function automatic string show(t_scan_result r);
        return $sformatf({"ok=%0d err=%0d done=%0d kept=%0d end=%0d count=%0d ",
                          "rv=%0d q=%0d ang=%0d rng=%0d pad=%0h"},
                         r.desc_ok, r.desc_err, r.rec_done, r.kept, r.frame_end, r.count,
                         r.rd_valid, r.quality, r.angle, r.range, r.pad);
    endfunction

    always @(posedge i_clk) begin : track
        t_scan_result got;
        t_scan_result want;
        if (!i_rst_n) begin
            link_en     = 1'b0;
            min_quality = '0;
            max_range   = 16'hFFFF;
            desc_word   = '0;
            fill_bank   = 1'b0;
            fill_count  = '0;
            shown_count = '0;
            in_scan     = 1'b0;
            byte_phase  = '0;
            gathered    = '0;
            expect_q.delete();
            o_pending <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_ENABLE:      link_en     = i_cfg_data[0];
                    CFG_MIN_QUALITY: min_quality = i_cfg_data[5:0];
                    CFG_MAX_RANGE:   max_range   = i_cfg_data[15:0];
                    CFG_EXPECT_DESC: desc_word   = i_cfg_data[55:0];
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata;
                if (expect_q.size() == 0) begin
                    failures++;
                    if (failures <= 10)
                        $display("unexpected result: %s", show(got));
                end else begin
                    want = expect_q.pop_front();
                    if (got !== want) begin
                        failures++;
                        if (failures <= 10) begin
                            $display("result mismatch, expected: %s", show(want));
                            $display("                   actual: %s", show(got));
                        end
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                expect_q.push_back(parse_item(t_item_op'(s_axis_tuser), s_axis_tdata[7:0],
                                              s_axis_tdata[15:8]));
            o_pending <= expect_q.size();
        end
    end

endmodule

// File: tb/tb.sv
module tb;
    import lsrp_pkg::*;
    import lsrp_tb_pkg::*;

    localparam int LONG_HOLD      = 200;   // cycles the sink refuses results once
    localparam int WATCHDOG_LIMIT = 3000;  // quiet cycles before giving up
    localparam int RANDOM_ITEMS   = 1100;

    logic                            i_clk         = 1'b0;
    logic                            i_rst_n       = 1'b0;
    logic                            i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]            i_cfg_idx     = '0;
    logic [CFG_DATA_W-1:0]           i_cfg_data    = '0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [15:0]                     s_axis_tdata  = '0;   // rx_byte[7:0], read_index[15:8]
    logic                            s_axis_tuser  = 1'b0; // op
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    // descriptor_ok, descriptor_error, record_done, point_kept, frame_end,
    // published_count, read_valid, read_quality, read_angle, read_range, pad
    logic [$bits(t_scan_result)-1:0] m_axis_tdata;

    int failures;
    int pending;

    // Stimulus-side knowledge used only to aim the random values
    logic [5:0]  cur_min_q   = '0;
    logic [15:0] cur_max_rng = 16'hFFFF;
    bit          link_on     = 1'b0;
    bit          send_burst  = 1'b0;
    bit          hold_request = 1'b0;
    int          items_sent  = 0;

    always #10 i_clk = ~i_clk;

    lidar_scan_record_parser_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    lsrp_scoreboard scoreboard (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .o_failures    (failures),
        .o_pending     (pending)
    );

    // Idle length: mostly none or short, now and then long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Quality aimed at the current threshold and at both ends
    function automatic logic [5:0] pick_quality();
        case ($urandom_range(0, 5))
            0:       return 6'd0;
            1:       return 6'd63;
            2:       return cur_min_q;
            3:       return (cur_min_q == 0) ? 6'd0 : cur_min_q - 6'd1;
            4:       return 6'($urandom_range(cur_min_q, 63));
            default: return 6'($urandom_range(0, 63));
        endcase
    endfunction

    // Range aimed at the current limit and at both ends
    function automatic logic [15:0] pick_range();
        case ($urandom_range(0, 5))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2:       return cur_max_rng;
            3:       return (cur_max_rng == 16'hFFFF) ? 16'hFFFF : cur_max_rng + 16'd1;
            4:       return 16'($urandom_range(0, cur_max_rng));
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // Read index: mostly inside what small frames publish
    function automatic logic [7:0] pick_index();
        if ($urandom_range(0, 9) < 6) return 8'($urandom_range(0, 24));
        return 8'($urandom_range(0, 255));
    endfunction

    // Any flag value except the one that closes a frame
    function automatic logic [1:0] pick_plain_flag();
        logic [1:0] f;
        f = 2'($urandom_range(0, 2));
        if (f == START_FLAG) f = 2'b11;
        return f;
    endfunction

    // Offer one item and hold it until the transfer happens. Valid stays
    // high afterwards so back-to-back items leave no gap on the stream.
    task automatic send_item(t_item_op op, logic [7:0] rx, logic [7:0] ix);
        int gap;
        gap = send_burst ? 0 : gap_len();
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {ix, rx};
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
        if (link_on) items_sent++;
    endtask

    // Unused field of each item gets random content
    task automatic send_byte(logic [7:0] b);
        send_item(OP_RX_BYTE, b, 8'($urandom));
    endtask

    task automatic send_read(logic [7:0] ix);
        send_item(OP_READ_POINT, 8'($urandom), ix);
    endtask

    task automatic send_record(logic [5:0] q, logic [14:0] ang, logic [15:0] rng,
                               logic [1:0] flag);
        logic chk;
        chk = 1'($urandom);
        send_byte({q, flag});
        send_byte({ang[6:0], chk});
        send_byte(ang[14:7]);
        send_byte(rng[7:0]);
        send_byte(rng[15:8]);
    endtask

    // One scan: plain records, then a record with the start flag. With noise,
    // sprinkle reads and stray bytes that knock the record framing off.
    task automatic send_frame(int n_rec, bit noisy);
        for (int k = 0; k < n_rec; k++) begin
            if (noisy && $urandom_range(0, 5) == 0) send_read(pick_index());
            if (noisy && $urandom_range(0, 39) == 0) send_byte(8'($urandom));
            send_record(pick_quality(), 15'($urandom), pick_range(),
                        (k == n_rec - 1) ? START_FLAG : pick_plain_flag());
        end
    endtask

    function automatic int frame_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(0, 15);
        if (r < 95) return $urandom_range(11, 40);
        return $urandom_range(60, 120);
    endfunction

    // Drop valid and wait until every result is back
    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            CFG_ENABLE:      link_on     = value[0];
            CFG_MIN_QUALITY: cur_min_q   = value[5:0];
            CFG_MAX_RANGE:   cur_max_rng = value[15:0];
            default: ;
        endcase
    endtask

    // Result sink: alternate runs of steady acceptance and random stalls;
    // honor one long hold-off when the stimulus asks for it.
    initial begin : result_sink
        int  stall;
        int  run_left;
        bit  steady;
        run_left = 0;
        steady   = 1'b0;
        forever begin
            @(negedge i_clk);
            if (run_left == 0) begin
                steady   = ($urandom_range(0, 2) == 0);
                run_left = $urandom_range(20, 150);
            end
            run_left--;
            if (hold_request) begin
                hold_request = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
            end else if (!steady && $urandom_range(0, 2) == 0) begin
                stall = gap_len();
                if (stall == 0) stall = 1;
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    // Give up when no transfer happens on either side for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial begin : stimulus
        logic [55:0] desc;
        int          phase;
        desc = 56'({$urandom, $urandom});

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Link still off: the byte is dropped, the read sees nothing published
        send_byte(desc[7:0]);
        send_read(8'd0);
        drain();
        write_reg(CFG_EXPECT_DESC, desc);
        write_reg(CFG_ENABLE, 56'd1);

        // Start a descriptor, switch the link off and on in the middle (the
        // byte in between is ignored, the gathered part kept), then finish
        // the group with wrong bytes so it is refused.
        for (int k = 0; k < 3; k++) send_byte(desc[8*k +: 8]);
        drain();
        write_reg(CFG_ENABLE, 56'd0);
        send_byte(8'($urandom));
        drain();
        write_reg(CFG_ENABLE, 56'd1);
        for (int k = 3; k < 7; k++) send_byte(~desc[8*k +: 8]);

        // Matching group: measuring starts
        for (int k = 0; k < 7; k++) send_byte(desc[8*k +: 8]);

        // Field extremes; a start flag on a short frame publishes nothing
        send_record(6'd63, 15'h7FFF, 16'hFFFF, 2'b10);
        send_record(6'd0, 15'd0, 16'd0, START_FLAG);
        send_read(8'd0);
        send_read(8'd255);

        // Overfill the working bank: records past its capacity are dropped,
        // then the full bank is published and read back across its range.
        drain();
        write_reg(CFG_MIN_QUALITY, 56'd0);
        write_reg(CFG_MAX_RANGE, 56'hFFFF);
        send_frame(262, 1'b0);
        send_read(8'd255);
        repeat (20) send_read(8'($urandom));

        // Stall the result side for a long stretch while items keep coming,
        // so the pipeline fills and the input side backs up.
        hold_request = 1'b1;
        send_burst   = 1'b1;
        repeat (40) send_read(8'($urandom));
        send_burst   = 1'b0;
        drain();

        // Random part: step through register settings between phases
        phase      = 0;
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS) begin
            drain();
            case (phase % 6)
                0: begin
                    write_reg(CFG_MIN_QUALITY, 56'd0);
                    write_reg(CFG_MAX_RANGE, 56'hFFFF);
                end
                1: begin
                    write_reg(CFG_MIN_QUALITY, 56'd63);
                    write_reg(CFG_MAX_RANGE, 56'd0);
                end
                2: begin
                    write_reg(CFG_MIN_QUALITY, 56'($urandom_range(0, 63)));
                    write_reg(CFG_MAX_RANGE, 56'($urandom_range(0, 65535)));
                end
                3: begin
                    // Link off: counts clear, bytes ignored, reads find nothing
                    write_reg(CFG_ENABLE, 56'd0);
                    repeat (12) begin
                        if ($urandom_range(0, 1) == 0) send_byte(8'($urandom));
                        else send_read(pick_index());
                    end
                    drain();
                    write_reg(CFG_ENABLE, 56'd1);
                end
                4: begin
                    write_reg(CFG_MIN_QUALITY, 56'd63);
                    write_reg(CFG_MAX_RANGE, 56'hFFFF);
                end
                default: begin
                    write_reg(CFG_MIN_QUALITY, 56'd0);
                    write_reg(CFG_MAX_RANGE, 56'd0);
                end
            endcase
            // Descriptor no longer matters once measuring; write its top value
            if (phase == 2) write_reg(CFG_EXPECT_DESC, '1);
            repeat (2) begin
                send_burst = ($urandom_range(0, 3) == 0);
                send_frame(frame_len(), 1'b1);
            end
            send_burst = 1'b0;
            phase++;
        end

        drain();
        repeat (8) @(posedge i_clk);
        if (failures == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
